/* hdl/assert_macros.svh */
// ----------------------------------------------------------------------------
// assert_macros : concurrent assertion helpers
// Shared macros for the checks at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is high
`define OBB_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("obb assertion failed");

// next-cycle implication, disabled while reset is high
`define OBB_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("obb assertion failed");

`endif

/* hdl/obb_pkg.sv */
// ----------------------------------------------------------------------------
// obb_pkg : shared constants of the oriented box overlap unit
// Parameter defaults and the numbering of the four candidate axes.
// ----------------------------------------------------------------------------
package obb_pkg;

   // default field formats
   localparam int COORD_WIDTH_DEF    = 24;
   localparam int TRIG_FRAC_BITS_DEF = 14;

   // candidate separating axes
   localparam int AXIS_COUNT = 4;
   localparam int AXIS_A_X   = 0;
   localparam int AXIS_A_Y   = 1;
   localparam int AXIS_B_X   = 2;
   localparam int AXIS_B_Y   = 3;

endpackage

/* hdl/obb_overlap_test_2d_unit.sv */
// ----------------------------------------------------------------------------
// obb_overlap_test_2d_unit : 2-D oriented rectangle overlap test
// Four-stage separating-axis test, one request a cycle unless rsp_stall holds.
// ----------------------------------------------------------------------------
// Usage
//   Request channel: req_valid with the two boxes (centre, full size and
//   cos/sin of the rotation); a request is taken on an edge where req_valid is
//   high and req_stall is low.
//   Response channel: rsp_valid with rsp_overlap, taken where rsp_stall is low.
//   rsp_overlap is 1 unless one of the four box axes separates the boxes;
//   boxes that only touch count as overlapping.
//   Each request passes through the difference and rotation products, the
//   projection products, the extent products, then the axis compares into
//   the response register.
//   Throughput is one request per cycle while the receiver does not stall;
//   every stage holds its own valid bit. When the receiver stalls, the stages
//   fill up behind the response register and req_stall rises only once all
//   four hold a request; nothing is lost or repeated.
//   Reset clears the valid bits and the occupancy count, not the payloads.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module obb_overlap_test_2d_unit #(
   parameter int COORD_WIDTH    = obb_pkg::COORD_WIDTH_DEF,
   parameter int TRIG_FRAC_BITS = obb_pkg::TRIG_FRAC_BITS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic signed [COORD_WIDTH-1:0]     req_box_a_x,
   input  logic signed [COORD_WIDTH-1:0]     req_box_a_y,
   input  logic        [COORD_WIDTH-2:0]     req_box_a_width,
   input  logic        [COORD_WIDTH-2:0]     req_box_a_height,
   input  logic signed [TRIG_FRAC_BITS+1:0]  req_box_a_cos,
   input  logic signed [TRIG_FRAC_BITS+1:0]  req_box_a_sin,
   input  logic signed [COORD_WIDTH-1:0]     req_box_b_x,
   input  logic signed [COORD_WIDTH-1:0]     req_box_b_y,
   input  logic        [COORD_WIDTH-2:0]     req_box_b_width,
   input  logic        [COORD_WIDTH-2:0]     req_box_b_height,
   input  logic signed [TRIG_FRAC_BITS+1:0]  req_box_b_cos,
   input  logic signed [TRIG_FRAC_BITS+1:0]  req_box_b_sin,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic                              rsp_overlap
);

   localparam int TW         = TRIG_FRAC_BITS + 2;
   localparam int PW         = 2 * TW;
   localparam int SW         = COORD_WIDTH - 1;
   localparam int QW         = COORD_WIDTH + 1 + TW;
   localparam int MW         = SW + PW;
   localparam int PIPE_DEPTH = 4;
   localparam int OCC_W      = $clog2(PIPE_DEPTH + 1);

   // stage one outputs
   logic                  s1_ready, s1_valid;
   logic signed [COORD_WIDTH:0] s1_dx, s1_dy;
   logic signed [PW-1:0]  s1_cc, s1_ss, s1_cs, s1_sc;
   logic [SW-1:0]         s1_a_w, s1_a_h, s1_b_w, s1_b_h;
   logic signed [TW-1:0]  s1_a_c, s1_a_s, s1_b_c, s1_b_s;

   // stage two outputs
   logic                  s2_ready, s2_valid;
   logic [PW-1:0]         s2_dot, s2_crs;
   logic signed [QW-1:0]  s2_dx_ca, s2_dy_sa, s2_dy_ca, s2_dx_sa;
   logic signed [QW-1:0]  s2_dx_cb, s2_dy_sb, s2_dy_cb, s2_dx_sb;
   logic [SW-1:0]         s2_a_w, s2_a_h, s2_b_w, s2_b_h;

   // stage three outputs
   logic                  s3_ready, s3_valid;
   logic [obb_pkg::AXIS_COUNT-1:0][QW-1:0] s3_dist;
   logic [obb_pkg::AXIS_COUNT-1:0][MW-1:0] s3_ext_w, s3_ext_h;
   logic [obb_pkg::AXIS_COUNT-1:0][SW-1:0] s3_own;

   // final stage
   logic                  s4_ready;
   logic                  rsp_ready;

   // requests in flight, for the checks below
   logic [OCC_W-1:0]      occ_ff, occ_in;

   assign rsp_ready = !rsp_stall;
   assign req_stall = !s1_ready;

   // difference and rotation products
   obb_delta #(
      .COORD_WIDTH    (COORD_WIDTH),
      .TRIG_FRAC_BITS (TRIG_FRAC_BITS)
   ) u_delta (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_ready  (s1_ready),
      .a_x       (req_box_a_x),
      .a_y       (req_box_a_y),
      .a_w       (req_box_a_width),
      .a_h       (req_box_a_height),
      .a_c       (req_box_a_cos),
      .a_s       (req_box_a_sin),
      .b_x       (req_box_b_x),
      .b_y       (req_box_b_y),
      .b_w       (req_box_b_width),
      .b_h       (req_box_b_height),
      .b_c       (req_box_b_cos),
      .b_s       (req_box_b_sin),
      .out_valid (s1_valid),
      .out_ready (s2_ready),
      .dx        (s1_dx),
      .dy        (s1_dy),
      .cc        (s1_cc),
      .ss        (s1_ss),
      .cs        (s1_cs),
      .sc        (s1_sc),
      .o_a_w     (s1_a_w),
      .o_a_h     (s1_a_h),
      .o_a_c     (s1_a_c),
      .o_a_s     (s1_a_s),
      .o_b_w     (s1_b_w),
      .o_b_h     (s1_b_h),
      .o_b_c     (s1_b_c),
      .o_b_s     (s1_b_s)
   );

   // relative rotation and centre projections
   obb_dot #(
      .COORD_WIDTH    (COORD_WIDTH),
      .TRIG_FRAC_BITS (TRIG_FRAC_BITS)
   ) u_dot (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s1_valid),
      .in_ready  (s2_ready),
      .dx        (s1_dx),
      .dy        (s1_dy),
      .cc        (s1_cc),
      .ss        (s1_ss),
      .cs        (s1_cs),
      .sc        (s1_sc),
      .a_w       (s1_a_w),
      .a_h       (s1_a_h),
      .a_c       (s1_a_c),
      .a_s       (s1_a_s),
      .b_w       (s1_b_w),
      .b_h       (s1_b_h),
      .b_c       (s1_b_c),
      .b_s       (s1_b_s),
      .out_valid (s2_valid),
      .out_ready (s3_ready),
      .dot_mag   (s2_dot),
      .crs_mag   (s2_crs),
      .dx_ca     (s2_dx_ca),
      .dy_sa     (s2_dy_sa),
      .dy_ca     (s2_dy_ca),
      .dx_sa     (s2_dx_sa),
      .dx_cb     (s2_dx_cb),
      .dy_sb     (s2_dy_sb),
      .dy_cb     (s2_dy_cb),
      .dx_sb     (s2_dx_sb),
      .o_a_w     (s2_a_w),
      .o_a_h     (s2_a_h),
      .o_b_w     (s2_b_w),
      .o_b_h     (s2_b_h)
   );

   // per-axis distance and projected extents
   obb_scale #(
      .COORD_WIDTH    (COORD_WIDTH),
      .TRIG_FRAC_BITS (TRIG_FRAC_BITS)
   ) u_scale (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s2_valid),
      .in_ready  (s3_ready),
      .dot_mag   (s2_dot),
      .crs_mag   (s2_crs),
      .dx_ca     (s2_dx_ca),
      .dy_sa     (s2_dy_sa),
      .dy_ca     (s2_dy_ca),
      .dx_sa     (s2_dx_sa),
      .dx_cb     (s2_dx_cb),
      .dy_sb     (s2_dy_sb),
      .dy_cb     (s2_dy_cb),
      .dx_sb     (s2_dx_sb),
      .a_w       (s2_a_w),
      .a_h       (s2_a_h),
      .b_w       (s2_b_w),
      .b_h       (s2_b_h),
      .out_valid (s3_valid),
      .out_ready (s4_ready),
      .dist_mag  (s3_dist),
      .ext_w     (s3_ext_w),
      .ext_h     (s3_ext_h),
      .own_len   (s3_own)
   );

   // axis compares and response register
   obb_axis #(
      .COORD_WIDTH    (COORD_WIDTH),
      .TRIG_FRAC_BITS (TRIG_FRAC_BITS)
   ) u_axis (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s3_valid),
      .in_ready  (s4_ready),
      .dist_mag  (s3_dist),
      .ext_w     (s3_ext_w),
      .ext_h     (s3_ext_h),
      .own_len   (s3_own),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .overlap   (rsp_overlap)
   );

   // occupancy count: requests taken less responses delivered
   always_comb begin
      occ_in = occ_ff;
      if (req_valid && !req_stall) begin
         occ_in = occ_in + OCC_W'(1);
      end
      if (rsp_valid && !rsp_stall) begin
         occ_in = occ_in - OCC_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         occ_ff <= '0;
      end else begin
         occ_ff <= occ_in;
      end
   end

   // checks
   `OBB_ASSERT_SAME(a_stall_only_when_full, clock, reset, req_stall,
      s1_valid && s2_valid && s3_valid && rsp_valid && rsp_stall)
   `OBB_ASSERT_SAME(a_occ_bounded, clock, reset, 1'b1, occ_ff <= OCC_W'(PIPE_DEPTH))
   `OBB_ASSERT_SAME(a_occ_matches_valids, clock, reset, 1'b1,
      occ_ff == OCC_W'($countones({s1_valid, s2_valid, s3_valid, rsp_valid})))
   `OBB_ASSERT_NEXT(a_held_response_stays, clock, reset, rsp_valid && rsp_stall,
      rsp_valid && $stable(rsp_overlap))

endmodule

/* hdl/obb_delta.sv */
// ----------------------------------------------------------------------------
// obb_delta : first pipeline stage
// Centre difference and the four cross products of the rotation pairs.
// ----------------------------------------------------------------------------
module obb_delta #(
   parameter int COORD_WIDTH    = obb_pkg::COORD_WIDTH_DEF,
   parameter int TRIG_FRAC_BITS = obb_pkg::TRIG_FRAC_BITS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              in_valid,
   output logic                              in_ready,
   input  logic signed [COORD_WIDTH-1:0]     a_x,
   input  logic signed [COORD_WIDTH-1:0]     a_y,
   input  logic        [COORD_WIDTH-2:0]     a_w,
   input  logic        [COORD_WIDTH-2:0]     a_h,
   input  logic signed [TRIG_FRAC_BITS+1:0]  a_c,
   input  logic signed [TRIG_FRAC_BITS+1:0]  a_s,
   input  logic signed [COORD_WIDTH-1:0]     b_x,
   input  logic signed [COORD_WIDTH-1:0]     b_y,
   input  logic        [COORD_WIDTH-2:0]     b_w,
   input  logic        [COORD_WIDTH-2:0]     b_h,
   input  logic signed [TRIG_FRAC_BITS+1:0]  b_c,
   input  logic signed [TRIG_FRAC_BITS+1:0]  b_s,
   output logic                              out_valid,
   input  logic                              out_ready,
   output logic signed [COORD_WIDTH:0]       dx,
   output logic signed [COORD_WIDTH:0]       dy,
   output logic signed [2*TRIG_FRAC_BITS+3:0] cc,
   output logic signed [2*TRIG_FRAC_BITS+3:0] ss,
   output logic signed [2*TRIG_FRAC_BITS+3:0] cs,
   output logic signed [2*TRIG_FRAC_BITS+3:0] sc,
   output logic        [COORD_WIDTH-2:0]     o_a_w,
   output logic        [COORD_WIDTH-2:0]     o_a_h,
   output logic signed [TRIG_FRAC_BITS+1:0]  o_a_c,
   output logic signed [TRIG_FRAC_BITS+1:0]  o_a_s,
   output logic        [COORD_WIDTH-2:0]     o_b_w,
   output logic        [COORD_WIDTH-2:0]     o_b_h,
   output logic signed [TRIG_FRAC_BITS+1:0]  o_b_c,
   output logic signed [TRIG_FRAC_BITS+1:0]  o_b_s
);

   localparam int TW = TRIG_FRAC_BITS + 2;
   localparam int PW = 2 * TW;
   localparam int SW = COORD_WIDTH - 1;

   logic                  valid_ff, valid_in;
   logic                  load;
   logic signed [COORD_WIDTH:0] dx_ff, dx_in, dy_ff, dy_in;
   logic signed [PW-1:0]  cc_ff, cc_in, ss_ff, ss_in, cs_ff, cs_in, sc_ff, sc_in;
   logic [SW-1:0]         a_w_ff, a_h_ff, b_w_ff, b_h_ff;
   logic signed [TW-1:0]  a_c_ff, a_s_ff, b_c_ff, b_s_ff;

   // stage handshake
   assign in_ready = !valid_ff || out_ready;
   assign load     = in_valid && in_ready;
   assign valid_in = in_ready ? in_valid : valid_ff;

   // centre difference and rotation cross products
   always_comb begin
      dx_in = (COORD_WIDTH+1)'(b_x) - (COORD_WIDTH+1)'(a_x);
      dy_in = (COORD_WIDTH+1)'(b_y) - (COORD_WIDTH+1)'(a_y);
      cc_in = PW'(a_c) * PW'(b_c);
      ss_in = PW'(a_s) * PW'(b_s);
      cs_in = PW'(a_c) * PW'(b_s);
      sc_in = PW'(a_s) * PW'(b_c);
   end

   // valid bit
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // stage payload
   always_ff @(posedge clock) begin
      if (load) begin
         dx_ff  <= dx_in;
         dy_ff  <= dy_in;
         cc_ff  <= cc_in;
         ss_ff  <= ss_in;
         cs_ff  <= cs_in;
         sc_ff  <= sc_in;
         a_w_ff <= a_w;
         a_h_ff <= a_h;
         a_c_ff <= a_c;
         a_s_ff <= a_s;
         b_w_ff <= b_w;
         b_h_ff <= b_h;
         b_c_ff <= b_c;
         b_s_ff <= b_s;
      end
   end

   assign out_valid = valid_ff;
   assign dx    = dx_ff;
   assign dy    = dy_ff;
   assign cc    = cc_ff;
   assign ss    = ss_ff;
   assign cs    = cs_ff;
   assign sc    = sc_ff;
   assign o_a_w = a_w_ff;
   assign o_a_h = a_h_ff;
   assign o_a_c = a_c_ff;
   assign o_a_s = a_s_ff;
   assign o_b_w = b_w_ff;
   assign o_b_h = b_h_ff;
   assign o_b_c = b_c_ff;
   assign o_b_s = b_s_ff;

endmodule

/* hdl/obb_dot.sv */
// ----------------------------------------------------------------------------
// obb_dot : second pipeline stage
// Magnitudes of the relative rotation terms and the centre projection products.
// ----------------------------------------------------------------------------
module obb_dot #(
   parameter int COORD_WIDTH    = obb_pkg::COORD_WIDTH_DEF,
   parameter int TRIG_FRAC_BITS = obb_pkg::TRIG_FRAC_BITS_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               in_valid,
   output logic                               in_ready,
   input  logic signed [COORD_WIDTH:0]        dx,
   input  logic signed [COORD_WIDTH:0]        dy,
   input  logic signed [2*TRIG_FRAC_BITS+3:0] cc,
   input  logic signed [2*TRIG_FRAC_BITS+3:0] ss,
   input  logic signed [2*TRIG_FRAC_BITS+3:0] cs,
   input  logic signed [2*TRIG_FRAC_BITS+3:0] sc,
   input  logic        [COORD_WIDTH-2:0]      a_w,
   input  logic        [COORD_WIDTH-2:0]      a_h,
   input  logic signed [TRIG_FRAC_BITS+1:0]   a_c,
   input  logic signed [TRIG_FRAC_BITS+1:0]   a_s,
   input  logic        [COORD_WIDTH-2:0]      b_w,
   input  logic        [COORD_WIDTH-2:0]      b_h,
   input  logic signed [TRIG_FRAC_BITS+1:0]   b_c,
   input  logic signed [TRIG_FRAC_BITS+1:0]   b_s,
   output logic                               out_valid,
   input  logic                               out_ready,
   output logic        [2*TRIG_FRAC_BITS+3:0] dot_mag,
   output logic        [2*TRIG_FRAC_BITS+3:0] crs_mag,
   output logic signed [COORD_WIDTH+TRIG_FRAC_BITS+2:0] dx_ca,
   output logic signed [COORD_WIDTH+TRIG_FRAC_BITS+2:0] dy_sa,
   output logic signed [COORD_WIDTH+TRIG_FRAC_BITS+2:0] dy_ca,
   output logic signed [COORD_WIDTH+TRIG_FRAC_BITS+2:0] dx_sa,
   output logic signed [COORD_WIDTH+TRIG_FRAC_BITS+2:0] dx_cb,
   output logic signed [COORD_WIDTH+TRIG_FRAC_BITS+2:0] dy_sb,
   output logic signed [COORD_WIDTH+TRIG_FRAC_BITS+2:0] dy_cb,
   output logic signed [COORD_WIDTH+TRIG_FRAC_BITS+2:0] dx_sb,
   output logic        [COORD_WIDTH-2:0]      o_a_w,
   output logic        [COORD_WIDTH-2:0]      o_a_h,
   output logic        [COORD_WIDTH-2:0]      o_b_w,
   output logic        [COORD_WIDTH-2:0]      o_b_h
);

   localparam int TW = TRIG_FRAC_BITS + 2;
   localparam int PW = 2 * TW;
   localparam int SW = COORD_WIDTH - 1;
   localparam int QW = COORD_WIDTH + 1 + TW;

   logic                  valid_ff, valid_in;
   logic                  load;
   logic signed [PW:0]    dot_sum, crs_sum;
   logic [PW-1:0]         dot_ff, dot_in, crs_ff, crs_in;
   logic signed [QW-1:0]  dx_ca_ff, dx_ca_in, dy_sa_ff, dy_sa_in;
   logic signed [QW-1:0]  dy_ca_ff, dy_ca_in, dx_sa_ff, dx_sa_in;
   logic signed [QW-1:0]  dx_cb_ff, dx_cb_in, dy_sb_ff, dy_sb_in;
   logic signed [QW-1:0]  dy_cb_ff, dy_cb_in, dx_sb_ff, dx_sb_in;
   logic [SW-1:0]         a_w_ff, a_h_ff, b_w_ff, b_h_ff;

   // stage handshake
   assign in_ready = !valid_ff || out_ready;
   assign load     = in_valid && in_ready;
   assign valid_in = in_ready ? in_valid : valid_ff;

   // |ca*cb + sa*sb| and |ca*sb - sa*cb|
   always_comb begin
      dot_sum = (PW+1)'(cc) + (PW+1)'(ss);
      crs_sum = (PW+1)'(cs) - (PW+1)'(sc);
      dot_in  = dot_sum[PW] ? PW'(-dot_sum) : PW'(dot_sum);
      crs_in  = crs_sum[PW] ? PW'(-crs_sum) : PW'(crs_sum);
   end

   // centre difference against each axis component
   always_comb begin
      dx_ca_in = QW'(dx) * QW'(a_c);
      dy_sa_in = QW'(dy) * QW'(a_s);
      dy_ca_in = QW'(dy) * QW'(a_c);
      dx_sa_in = QW'(dx) * QW'(a_s);
      dx_cb_in = QW'(dx) * QW'(b_c);
      dy_sb_in = QW'(dy) * QW'(b_s);
      dy_cb_in = QW'(dy) * QW'(b_c);
      dx_sb_in = QW'(dx) * QW'(b_s);
   end

   // valid bit
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // stage payload
   always_ff @(posedge clock) begin
      if (load) begin
         dot_ff   <= dot_in;
         crs_ff   <= crs_in;
         dx_ca_ff <= dx_ca_in;
         dy_sa_ff <= dy_sa_in;
         dy_ca_ff <= dy_ca_in;
         dx_sa_ff <= dx_sa_in;
         dx_cb_ff <= dx_cb_in;
         dy_sb_ff <= dy_sb_in;
         dy_cb_ff <= dy_cb_in;
         dx_sb_ff <= dx_sb_in;
         a_w_ff   <= a_w;
         a_h_ff   <= a_h;
         b_w_ff   <= b_w;
         b_h_ff   <= b_h;
      end
   end

   assign out_valid = valid_ff;
   assign dot_mag   = dot_ff;
   assign crs_mag   = crs_ff;
   assign dx_ca     = dx_ca_ff;
   assign dy_sa     = dy_sa_ff;
   assign dy_ca     = dy_ca_ff;
   assign dx_sa     = dx_sa_ff;
   assign dx_cb     = dx_cb_ff;
   assign dy_sb     = dy_sb_ff;
   assign dy_cb     = dy_cb_ff;
   assign dx_sb     = dx_sb_ff;
   assign o_a_w     = a_w_ff;
   assign o_a_h     = a_h_ff;
   assign o_b_w     = b_w_ff;
   assign o_b_h     = b_h_ff;

endmodule

/* hdl/obb_scale.sv */
// ----------------------------------------------------------------------------
// obb_scale : third pipeline stage
// Per axis: centre distance magnitude and the other box's projected extents.
// ----------------------------------------------------------------------------
module obb_scale #(
   parameter int COORD_WIDTH    = obb_pkg::COORD_WIDTH_DEF,
   parameter int TRIG_FRAC_BITS = obb_pkg::TRIG_FRAC_BITS_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               in_valid,
   output logic                               in_ready,
   input  logic        [2*TRIG_FRAC_BITS+3:0] dot_mag,
   input  logic        [2*TRIG_FRAC_BITS+3:0] crs_mag,
   input  logic signed [COORD_WIDTH+TRIG_FRAC_BITS+2:0] dx_ca,
   input  logic signed [COORD_WIDTH+TRIG_FRAC_BITS+2:0] dy_sa,
   input  logic signed [COORD_WIDTH+TRIG_FRAC_BITS+2:0] dy_ca,
   input  logic signed [COORD_WIDTH+TRIG_FRAC_BITS+2:0] dx_sa,
   input  logic signed [COORD_WIDTH+TRIG_FRAC_BITS+2:0] dx_cb,
   input  logic signed [COORD_WIDTH+TRIG_FRAC_BITS+2:0] dy_sb,
   input  logic signed [COORD_WIDTH+TRIG_FRAC_BITS+2:0] dy_cb,
   input  logic signed [COORD_WIDTH+TRIG_FRAC_BITS+2:0] dx_sb,
   input  logic        [COORD_WIDTH-2:0]      a_w,
   input  logic        [COORD_WIDTH-2:0]      a_h,
   input  logic        [COORD_WIDTH-2:0]      b_w,
   input  logic        [COORD_WIDTH-2:0]      b_h,
   output logic                               out_valid,
   input  logic                               out_ready,
   output logic [obb_pkg::AXIS_COUNT-1:0][COORD_WIDTH+TRIG_FRAC_BITS+2:0] dist_mag,
   output logic [obb_pkg::AXIS_COUNT-1:0][COORD_WIDTH+2*TRIG_FRAC_BITS+2:0] ext_w,
   output logic [obb_pkg::AXIS_COUNT-1:0][COORD_WIDTH+2*TRIG_FRAC_BITS+2:0] ext_h,
   output logic [obb_pkg::AXIS_COUNT-1:0][COORD_WIDTH-2:0] own_len
);

   localparam int TW = TRIG_FRAC_BITS + 2;
   localparam int PW = 2 * TW;
   localparam int SW = COORD_WIDTH - 1;
   localparam int QW = COORD_WIDTH + 1 + TW;
   localparam int MW = SW + PW;

   logic                  valid_ff, valid_in;
   logic                  load;
   logic signed [QW:0]    pd_sum [obb_pkg::AXIS_COUNT];
   logic [obb_pkg::AXIS_COUNT-1:0][QW-1:0] dist_ff, dist_in;
   logic [obb_pkg::AXIS_COUNT-1:0][MW-1:0] ext_w_ff, ext_w_in, ext_h_ff, ext_h_in;
   logic [obb_pkg::AXIS_COUNT-1:0][SW-1:0] own_ff, own_in;

   // stage handshake
   assign in_ready = !valid_ff || out_ready;
   assign load     = in_valid && in_ready;
   assign valid_in = in_ready ? in_valid : valid_ff;

   // projected centre distance on each axis
   always_comb begin
      pd_sum[obb_pkg::AXIS_A_X] = (QW+1)'(dx_ca) + (QW+1)'(dy_sa);
      pd_sum[obb_pkg::AXIS_A_Y] = (QW+1)'(dy_ca) - (QW+1)'(dx_sa);
      pd_sum[obb_pkg::AXIS_B_X] = (QW+1)'(dx_cb) + (QW+1)'(dy_sb);
      pd_sum[obb_pkg::AXIS_B_Y] = (QW+1)'(dy_cb) - (QW+1)'(dx_sb);
      for (int i = 0; i < obb_pkg::AXIS_COUNT; i++) begin
         dist_in[i] = pd_sum[i][QW] ? QW'(-pd_sum[i]) : QW'(pd_sum[i]);
      end
   end

   // other box's half-extents projected on each axis, scaled by 2^(2F+1)
   always_comb begin
      ext_w_in[obb_pkg::AXIS_A_X] = MW'(b_w) * MW'(dot_mag);
      ext_h_in[obb_pkg::AXIS_A_X] = MW'(b_h) * MW'(crs_mag);
      ext_w_in[obb_pkg::AXIS_A_Y] = MW'(b_w) * MW'(crs_mag);
      ext_h_in[obb_pkg::AXIS_A_Y] = MW'(b_h) * MW'(dot_mag);
      ext_w_in[obb_pkg::AXIS_B_X] = MW'(a_w) * MW'(dot_mag);
      ext_h_in[obb_pkg::AXIS_B_X] = MW'(a_h) * MW'(crs_mag);
      ext_w_in[obb_pkg::AXIS_B_Y] = MW'(a_w) * MW'(crs_mag);
      ext_h_in[obb_pkg::AXIS_B_Y] = MW'(a_h) * MW'(dot_mag);
      own_in[obb_pkg::AXIS_A_X]   = a_w;
      own_in[obb_pkg::AXIS_A_Y]   = a_h;
      own_in[obb_pkg::AXIS_B_X]   = b_w;
      own_in[obb_pkg::AXIS_B_Y]   = b_h;
   end

   // valid bit
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // stage payload
   always_ff @(posedge clock) begin
      if (load) begin
         dist_ff  <= dist_in;
         ext_w_ff <= ext_w_in;
         ext_h_ff <= ext_h_in;
         own_ff   <= own_in;
      end
   end

   assign out_valid = valid_ff;
   assign dist_mag  = dist_ff;
   assign ext_w     = ext_w_ff;
   assign ext_h     = ext_h_ff;
   assign own_len   = own_ff;

endmodule

/* hdl/obb_axis.sv */
// ----------------------------------------------------------------------------
// obb_axis : final pipeline stage
// Four separating-axis compares and the registered overlap response.
// ----------------------------------------------------------------------------
module obb_axis #(
   parameter int COORD_WIDTH    = obb_pkg::COORD_WIDTH_DEF,
   parameter int TRIG_FRAC_BITS = obb_pkg::TRIG_FRAC_BITS_DEF
) (
   input  logic clock,
   input  logic reset,
   input  logic in_valid,
   output logic in_ready,
   input  logic [obb_pkg::AXIS_COUNT-1:0][COORD_WIDTH+TRIG_FRAC_BITS+2:0] dist_mag,
   input  logic [obb_pkg::AXIS_COUNT-1:0][COORD_WIDTH+2*TRIG_FRAC_BITS+2:0] ext_w,
   input  logic [obb_pkg::AXIS_COUNT-1:0][COORD_WIDTH+2*TRIG_FRAC_BITS+2:0] ext_h,
   input  logic [obb_pkg::AXIS_COUNT-1:0][COORD_WIDTH-2:0] own_len,
   output logic out_valid,
   input  logic out_ready,
   output logic overlap
);

   localparam int TW   = TRIG_FRAC_BITS + 2;
   localparam int SW   = COORD_WIDTH - 1;
   localparam int MW   = SW + 2 * TW;
   localparam int CMPW = MW + 2;

   logic                             valid_ff, valid_in;
   logic                             load;
   logic                             overlap_ff, overlap_in;
   logic [CMPW-1:0]                  lhs [obb_pkg::AXIS_COUNT];
   logic [CMPW-1:0]                  rhs [obb_pkg::AXIS_COUNT];
   logic [obb_pkg::AXIS_COUNT-1:0]   sep;

   // stage handshake
   assign in_ready = !valid_ff || out_ready;
   assign load     = in_valid && in_ready;
   assign valid_in = in_ready ? in_valid : valid_ff;

   // extent sum against centre distance, both scaled by 2^(2F+1)
   always_comb begin
      for (int i = 0; i < obb_pkg::AXIS_COUNT; i++) begin
         lhs[i] = (CMPW'(own_len[i]) << (2 * TRIG_FRAC_BITS))
                + CMPW'(ext_w[i]) + CMPW'(ext_h[i]);
         rhs[i] = CMPW'(dist_mag[i]) << (TRIG_FRAC_BITS + 1);
         sep[i] = lhs[i] < rhs[i];
      end
      overlap_in = ~|sep;
   end

   // response valid
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // response payload
   always_ff @(posedge clock) begin
      if (load) begin
         overlap_ff <= overlap_in;
      end
   end

   assign out_valid = valid_ff;
   assign overlap   = overlap_ff;

endmodule
